// File: sv/q64md_pkg.sv
`default_nettype none
package q64md_pkg;

    localparam int FRAC_BITS = 64;
    localparam int DIV_STEPS = 128 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 16;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_MINV = 2'd2,
        OP_INV  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVF     = 2'd1,
        ST_DIV0    = 2'd2,
        ST_INV_ARG = 2'd3
    } status_t;

    typedef struct packed {
        logic       load;
        logic       init_mul;
        logic       init_div;
        logic       mul_step;
        logic [3:0] mul_idx;
        logic       div_step;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic early_err;
    } dp_stat_t;

    // Magnitude m is representable as a signed 128-bit value with sign neg.
    function automatic logic fits(input logic [127:0] m, input logic neg);
        logic r;
        if (neg)
        begin
            r = !(m[127] && (|m[126:0]));
        end
        else
        begin
            r = !m[127];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/q64md_ctrl.sv
`default_nettype none
module q64md_ctrl
    import q64md_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t dp_stat,
    output cmd_t          cmd,
    output logic          busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_MINIT = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_idx = cnt_reg[3:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cnt_next = '0;
                if (dp_stat.early_err)
                begin
                    state_next = S_FIN;
                end
                else if (dp_stat.op == OP_MUL || dp_stat.op == OP_MINV)
                begin
                    state_next = S_MINIT;
                end
                else
                begin
                    cmd.init_div = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_MINIT:
            begin
                cmd.init_mul = 1'b1;
                cnt_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = (dp_stat.op == OP_INV) ? S_MINIT : S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// File: sv/q64md_dp.sv
`default_nettype none
module q64md_dp
    import q64md_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cmd_t         cmd,
    output dp_stat_t          dp_stat,
    input  wire logic [1:0]   op,
    input  wire logic [63:0]  a_high,
    input  wire logic [63:0]  a_low,
    input  wire logic [63:0]  b_high,
    input  wire logic [63:0]  b_low,
    input  wire logic [63:0]  recip_source,
    output logic              done,
    output logic [63:0]       result_high,
    output logic [63:0]       result_low,
    output logic [1:0]        status
);

    op_t            op_reg;
    logic           neg_reg;
    status_t        err_reg;
    logic [127:0]   a_mag_reg, b_val_reg;
    logic [63:0]    v_reg;
    logic [127:0]   n_reg, d_reg, r_reg, q_reg;
    logic           dovf_reg;
    logic [127:0]   ma_reg, mb_reg;
    logic [63:0]    prod_reg;
    logic [2:0]     psh_reg;
    logic           pv_reg;
    logic [255:0]   acc_reg;
    logic [63:0]    res_hi_reg, res_lo_reg;
    status_t        stat_reg;
    logic           done_reg;

    logic [127:0]   a_in, b_in, a_mag, b_mag;
    logic           na, nb;
    status_t        err_next;
    logic           neg_next;
    logic [127:0]   r_sh;
    logic           ge;
    logic [1:0]     li, lj;
    logic [31:0]    la, lb;
    logic           skip;
    logic [255:0]   addend;
    logic [127:0]   m, m_neg;
    logic           ovf;
    status_t        stat_next;

    // Operand magnitudes and early error checks.
    always_comb
    begin
        a_in  = {a_high, a_low};
        b_in  = {b_high, b_low};
        na    = a_in[127];
        nb    = b_in[127];
        a_mag = na ? (~a_in + 128'd1) : a_in;
        b_mag = nb ? (~b_in + 128'd1) : b_in;
        err_next = ST_OK;
        neg_next = na ^ nb;
        case (op_t'(op))
            OP_DIV:
            begin
                if (b_in == '0)
                begin
                    err_next = ST_DIV0;
                end
            end
            OP_MINV:
            begin
                neg_next = na;
                if (b_in[127] && (|b_in[126:0]))
                begin
                    err_next = ST_OVF;
                end
            end
            OP_INV:
            begin
                neg_next = 1'b0;
                if (recip_source[63:1] == '0)
                begin
                    err_next = ST_INV_ARG;
                end
            end
            default:
            begin
                neg_next = na ^ nb;
            end
        endcase
    end

    // Restoring division step.
    always_comb
    begin
        r_sh = {r_reg[126:0], n_reg[127]};
        ge   = (r_sh >= d_reg);
    end

    // One 32x32 partial product per step.
    always_comb
    begin
        li     = cmd.mul_idx[3:2];
        lj     = cmd.mul_idx[1:0];
        la     = ma_reg[32*li +: 32];
        lb     = mb_reg[32*lj +: 32];
        skip   = (op_reg == OP_MINV) && !li[1] && !lj[1];
        addend = {192'd0, prod_reg} << {psh_reg, 5'd0};
    end

    // Final result selection.
    always_comb
    begin
        m   = q_reg;
        ovf = 1'b0;
        case (op_reg)
            OP_MUL:
            begin
                m   = acc_reg[191:64];
                ovf = (|acc_reg[255:192]) || !fits(m, neg_reg);
            end
            OP_DIV:
            begin
                m   = q_reg;
                ovf = dovf_reg || !fits(m, neg_reg);
            end
            OP_MINV:
            begin
                m = acc_reg[255:128];
            end
            OP_INV:
            begin
                m = q_reg + {127'd0, (acc_reg[255:192] != 64'd1)};
            end
            default:
            begin
                m = q_reg;
            end
        endcase
        m_neg = neg_reg ? (~m + 128'd1) : m;
        if (err_reg != ST_OK)
        begin
            stat_next = err_reg;
        end
        else if (ovf)
        begin
            stat_next = ST_OVF;
        end
        else
        begin
            stat_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(op);
            neg_reg   <= neg_next;
            err_reg   <= err_next;
            a_mag_reg <= a_mag;
            b_val_reg <= (op_t'(op) == OP_MINV) ? b_in : b_mag;
            v_reg     <= recip_source;
        end
        if (cmd.init_div)
        begin
            n_reg    <= (op_reg == OP_INV) ? {64'd1, 64'd0} : a_mag_reg;
            d_reg    <= (op_reg == OP_INV) ? {64'd0, v_reg} : b_val_reg;
            r_reg    <= '0;
            q_reg    <= '0;
            dovf_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            n_reg    <= {n_reg[126:0], 1'b0};
            r_reg    <= ge ? (r_sh - d_reg) : r_sh;
            q_reg    <= {q_reg[126:0], ge};
            dovf_reg <= dovf_reg | q_reg[127];
        end
        if (cmd.init_mul)
        begin
            ma_reg  <= (op_reg == OP_INV) ? {v_reg, 64'd0} : a_mag_reg;
            mb_reg  <= (op_reg == OP_INV) ? q_reg : b_val_reg;
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= skip ? 64'd0 : (64'(la) * 64'(lb));
            psh_reg  <= {1'b0, li} + {1'b0, lj};
        end
        if (cmd.finish)
        begin
            res_hi_reg <= (stat_next == ST_OK) ? m_neg[127:64] : 64'd0;
            res_lo_reg <= (stat_next == ST_OK) ? m_neg[63:0] : 64'd0;
            stat_reg   <= stat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= cmd.mul_step;
            done_reg <= cmd.finish;
        end
    end

    assign dp_stat.op        = op_reg;
    assign dp_stat.early_err = (err_reg != ST_OK);
    assign done        = done_reg;
    assign result_high = res_hi_reg;
    assign result_low  = res_lo_reg;
    assign status      = stat_reg;

endmodule
`default_nettype wire

// File: sv/q64_64_mul_div_unit_top.sv
`default_nettype none
// Channel   Handshake        Ports
// request   start / busy     op, a_high, a_low, b_high, b_low, recip_source
// result    done (strobe)    result_high, result_low, status
//
// A request is taken when start is high and busy is low.
// Multiply and multiply-by-inverse use 16 steps of one 32x32 multiplier.
// Divide runs 192 restoring steps through one 128-bit subtractor.
// Invert runs the divide, then a 16-step check multiply.
// Errors found at load go straight to finish. Reset clears only control state.
// done is high one cycle per result; the receiver cannot stall it.
module q64_64_mul_div_unit_top
    import q64md_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   op,
    input  wire logic [63:0]  a_high,
    input  wire logic [63:0]  a_low,
    input  wire logic [63:0]  b_high,
    input  wire logic [63:0]  b_low,
    input  wire logic [63:0]  recip_source,
    output logic              done,
    output logic [63:0]       result_high,
    output logic [63:0]       result_low,
    output logic [1:0]        status
);

    cmd_t     cmd;
    dp_stat_t dp_stat;

    // Sequence the request: load, divide and/or multiply, finish.
    q64md_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Hold operands, divider, multiplier accumulator and result register.
    q64md_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .op           (op),
        .a_high       (a_high),
        .a_low        (a_low),
        .b_high       (b_high),
        .b_low        (b_low),
        .recip_source (recip_source),
        .done         (done),
        .result_high  (result_high),
        .result_low   (result_low),
        .status       (status)
    );

    // A taken request keeps the unit busy next cycle.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but unit not busy");

    // A result only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in progress");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_high == '0 && result_low == '0))
        else $error("error result with nonzero value");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Scoreboard for the Q64.64 unit: predicts each request's result and checks the strobed output.
class q64_scoreboard;
    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [1:0]  st;
    } q64_result_t;

    q64_result_t pending[$];
    int          fail_count = 0;

    static function logic [127:0] mul_full(logic [63:0] x, logic [63:0] y);
        logic [127:0] xx;
        logic [127:0] yy;
        xx = {64'd0, x};
        yy = {64'd0, y};
        return xx * yy;
    endfunction

    static function logic fits_signed(logic [127:0] m, logic neg);
        if (neg)
            return !(m[127] && (|m[126:0]));
        return !m[127];
    endfunction

    // Compute what the unit must return for one request.
    static function q64_result_t compute(q64md_pkg::op_t op, logic [63:0] ah, logic [63:0] al,
                                         logic [63:0] bh, logic [63:0] bl, logic [63:0] v);
        q64_result_t  res;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] r;
        logic [127:0] hp;
        logic [127:0] mid;
        logic [127:0] q;
        logic [127:0] chk;
        logic [255:0] wide;
        logic [64:0]  hsum;
        logic         na;
        logic         nb;
        res.hi = '0;
        res.lo = '0;
        res.st = q64md_pkg::ST_OK;
        na = ah[63];
        nb = bh[63];
        a = na ? -{ah, al} : {ah, al};
        b = nb ? -{bh, bl} : {bh, bl};
        case (op)
            q64md_pkg::OP_MUL:
            begin
                r = (mul_full(a[63:0], b[63:0]) >> 64) + mul_full(a[127:64], b[63:0])
                    + mul_full(a[63:0], b[127:64]);
                hp = mul_full(a[127:64], b[127:64]);
                if (hp[127:64] != 0 || hp[63:0] > 64'h8000_0000_0000_0000)
                    res.st = q64md_pkg::ST_OVF;
                else
                begin
                    hsum = {1'b0, r[127:64]} + {1'b0, hp[63:0]};
                    if (hsum[64])
                        res.st = q64md_pkg::ST_OVF;
                    else
                    begin
                        r[127:64] = hsum[63:0];
                        if (!fits_signed(r, na != nb))
                            res.st = q64md_pkg::ST_OVF;
                        else
                            {res.hi, res.lo} = (na != nb) ? -r : r;
                    end
                end
            end
            q64md_pkg::OP_DIV:
            begin
                if (b == 0)
                    res.st = q64md_pkg::ST_DIV0;
                else
                begin
                    wide = {64'd0, a, 64'd0} / {128'd0, b};
                    q = wide[127:0];
                    if (wide[255:128] != 0 || !fits_signed(q, na != nb))
                        res.st = q64md_pkg::ST_OVF;
                    else
                        {res.hi, res.lo} = (na != nb) ? -q : q;
                end
            end
            q64md_pkg::OP_MINV:
            begin
                b = {bh, bl};
                if (b > {1'b1, 127'd0})
                    res.st = q64md_pkg::ST_OVF;
                else
                begin
                    mid = mul_full(a[127:64], b[63:0]) + mul_full(a[63:0], b[127:64]);
                    r = mul_full(a[127:64], b[127:64]) + (mid >> 64);
                    {res.hi, res.lo} = na ? -r : r;
                end
            end
            default:
            begin
                if (v < 2)
                    res.st = q64md_pkg::ST_INV_ARG;
                else
                begin
                    wide = {127'd0, 1'b1, 128'd0} / {192'd0, v};
                    q = wide[127:0];
                    chk = mul_full(v, q[127:64]) + (mul_full(v, q[63:0]) >> 64);
                    if (chk[127:64] != 1)
                        q = q + 1;
                    {res.hi, res.lo} = q;
                end
            end
        endcase
        return res;
    endfunction

    function void note_request(q64md_pkg::op_t op, logic [63:0] ah, logic [63:0] al,
                               logic [63:0] bh, logic [63:0] bl, logic [63:0] v);
        pending.push_back(compute(op, ah, al, bh, bl, v));
    endfunction

    function void check_result(logic [63:0] hi, logic [63:0] lo, logic [1:0] st);
        q64_result_t want;
        if (pending.size() == 0)
        begin
            $error("result with nothing pending: high %h low %h status %0d", hi, lo, st);
            fail_count++;
            return;
        end
        want = pending.pop_front();
        if (hi !== want.hi)
        begin
            $error("result_high: expected %h, got %h", want.hi, hi);
            fail_count++;
        end
        if (lo !== want.lo)
        begin
            $error("result_low: expected %h, got %h", want.lo, lo);
            fail_count++;
        end
        if (st !== want.st)
        begin
            $error("status: expected %0d, got %0d", want.st, st);
            fail_count++;
        end
    endfunction
endclass

module tb_top;
    import q64md_pkg::*;

    localparam int RANDOM_REQUESTS = 1650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  op = OP_MUL;
    logic [63:0] a_high = '0;
    logic [63:0] a_low = '0;
    logic [63:0] b_high = '0;
    logic [63:0] b_low = '0;
    logic [63:0] recip_source = '0;
    logic        busy;
    logic        done;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [1:0]  status;

    q64_scoreboard sb = new();
    int            req_index = 0;

    q64_64_mul_div_unit_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .a_high       (a_high),
        .a_low        (a_low),
        .b_high       (b_high),
        .b_low        (b_low),
        .recip_source (recip_source),
        .done         (done),
        .result_high  (result_high),
        .result_low   (result_low),
        .status       (status)
    );

    always #5 clk = ~clk;

    // Results stay on the ports for the whole cycle; sample them mid-cycle to avoid races.
    always @(negedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result_high, result_low, status);
    end

    // Drop start for a random number of cycles; none inside the burst window.
    task automatic idle_gap();
        if (req_index >= 700 && req_index < 1000)
            return;
        while ($urandom_range(99) < 19)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Present one request and hold it until the unit takes it.
    task automatic send_request(op_t o, logic [63:0] ah, logic [63:0] al,
                                logic [63:0] bh, logic [63:0] bl, logic [63:0] v);
        logic taken;
        idle_gap();
        start        <= 1'b1;
        op           <= o;
        a_high       <= ah;
        a_low        <= al;
        b_high       <= bh;
        b_low        <= bl;
        recip_source <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        sb.note_request(o, ah, al, bh, bl, v);
        req_index++;
    endtask

    // Mix full-range words with small signed values and edge patterns.
    function automatic logic [63:0] pick_word(bit is_high);
        logic [63:0] w;
        int          kind;
        kind = $urandom_range(9);
        w = {$urandom, $urandom};
        if (kind < 3)
            return w;
        if (kind < 8)
        begin
            if (is_high)
                return $signed({{48{w[15]}}, w[15:0]}) >>> $urandom_range(15);
            return w >> $urandom_range(63);
        end
        case ($urandom_range(5))
            0: w = 64'd0;
            1: w = 64'd1;
            2: w = 64'hFFFF_FFFF_FFFF_FFFF;
            3: w = 64'h8000_0000_0000_0000;
            4: w = 64'h7FFF_FFFF_FFFF_FFFF;
            default: w = 64'd2;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] pick_recip();
        case ($urandom_range(7))
            0: return 64'($urandom_range(3));
            1: return {$urandom, $urandom};
            2: return 64'd1 << $urandom_range(63);
            default: return {32'd0, $urandom} >> $urandom_range(31);
        endcase
    endfunction

    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    initial
    begin
        int   i;
        op_t  o;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every operation and each error path.
        send_request(OP_MUL,  64'd1, 64'd0, 64'd1, 64'd0, 64'd0);
        send_request(OP_MUL,  MAX_POS, ONES, MAX_POS, ONES, ONES);
        send_request(OP_MUL,  MIN_NEG, 64'd0, 64'd1, 64'd0, 64'd0);
        send_request(OP_MUL,  MIN_NEG, 64'd0, ONES, 64'd0, 64'd0);
        send_request(OP_MUL,  64'd0, ONES, 64'd0, ONES, 64'd0);
        send_request(OP_MUL,  ONES, ONES, ONES, ONES, 64'd0);
        send_request(OP_DIV,  64'd1, 64'd0, 64'd0, 64'd0, 64'd0);
        send_request(OP_DIV,  64'd1, 64'd0, 64'd3, 64'd0, 64'd0);
        send_request(OP_DIV,  MIN_NEG, 64'd0, 64'd1, 64'd0, 64'd0);
        send_request(OP_DIV,  MIN_NEG, 64'd0, ONES, 64'd0, 64'd0);
        send_request(OP_DIV,  MAX_POS, ONES, 64'd0, 64'd1, 64'd0);
        send_request(OP_DIV,  ONES, ONES, MIN_NEG, 64'd0, 64'd0);
        send_request(OP_MINV, 64'd5, 64'd7, MIN_NEG, 64'd0, 64'd0);
        send_request(OP_MINV, 64'd5, 64'd7, MIN_NEG, 64'd1, 64'd0);
        send_request(OP_MINV, ONES, 64'd3, 64'd0, ONES, 64'd0);
        send_request(OP_MINV, MIN_NEG, 64'd0, 64'd1, ONES, 64'd0);
        send_request(OP_INV,  64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_request(OP_INV,  64'd0, 64'd0, 64'd0, 64'd0, 64'd1);
        send_request(OP_INV,  64'd0, 64'd0, 64'd0, 64'd0, 64'd2);
        send_request(OP_INV,  64'd0, 64'd0, 64'd0, 64'd0, 64'd3);
        send_request(OP_INV,  ONES, ONES, ONES, ONES, MIN_NEG);
        send_request(OP_INV,  MAX_POS, 64'd0, MAX_POS, 64'd0, ONES);

        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Hold off once until the unit has drained everything.
            if (i == 1200)
            begin
                start <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            o = op_t'($urandom_range(3));
            send_request(o, pick_word(1'b1), pick_word(1'b0), pick_word(1'b1),
                         pick_word(1'b0), pick_recip());
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial
    begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
